// File: rtl/station_address_learner_assert.svh
// assertion macros used by the top-level rtl file
`ifndef STATION_ADDRESS_LEARNER_ASSERT_SVH
`define STATION_ADDRESS_LEARNER_ASSERT_SVH

// same-cycle implication, held off during reset
`define SAL_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define SAL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sal_pkg.sv
`timescale 1ns / 1ps

package sal_pkg;

    // field widths
    localparam int ADDR_W    = 48;
    localparam int REQ_W     = 3;
    localparam int LEN_W     = 16;
    localparam int IDX_W     = 5;
    localparam int CNT_OUT_W = 6;

    // frame filtering constants
    localparam logic [ADDR_W-1:0] BCAST_ADDR      = 48'hFFFF_FFFF_FFFF;
    localparam logic [23:0]       MCAST_V4_PREFIX = 24'h01005E;
    localparam logic [23:0]       MCAST_V6_PREFIX = 24'h333300;
    localparam logic [LEN_W-1:0]  MIN_FRAME_LEN   = 16'd12;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_FRAME     = 3'd0,
        REQ_CLEAR     = 3'd1,
        REQ_READ      = 3'd2,
        REQ_TOGGLE    = 3'd3,
        REQ_SEL_ALL   = 3'd4,
        REQ_DESEL_ALL = 3'd5
    } t_req;

    // one station table word
    typedef struct packed {
        logic              sel;
        logic [ADDR_W-1:0] addr;
    } t_entry;

endpackage

// File: rtl/sal_table_ram.sv
`timescale 1ns / 1ps

module sal_table_ram import sal_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sal_engine.sv
`timescale 1ns / 1ps

module sal_engine import sal_pkg::*; #(
    parameter int MAX_STATIONS = 32,
    parameter int IW           = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [ADDR_W-1:0]    i_target_bssid,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [ADDR_W-1:0]    i_receiver_addr,
    input  logic [ADDR_W-1:0]    i_transmitter_addr,
    input  logic [LEN_W-1:0]     i_frame_length,
    input  logic [IDX_W-1:0]     i_entry_index,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CNT_OUT_W-1:0] o_station_count,
    output logic                 o_learned_new,
    output logic [ADDR_W-1:0]    o_entry_addr,
    output logic                 o_entry_selected,
    output logic                 o_entry_valid,
    // table memory
    output logic                 o_we,
    output logic [IW-1:0]        o_waddr,
    output t_entry               o_wdata,
    output logic [IW-1:0]        o_raddr,
    input  t_entry               i_rdata
);

    localparam int CW = $clog2(MAX_STATIONS + 1);
    localparam int KW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_INSERT,
        S_INDEX_RD,
        S_INDEX_DATA,
        S_SWEEP,
        S_PUSH
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_k;
    logic              r_pend;
    logic [IW-1:0]     r_wk;
    logic [ADDR_W-1:0] r_cand;
    logic [KW-1:0]     r_idx;
    logic              r_toggle;
    logic              r_sel_val;
    logic              r_res_learned;
    logic [ADDR_W-1:0] r_res_addr;
    logic              r_res_sel;
    logic              r_res_valid;

    logic              w_rx_is_ap;
    logic              w_tx_is_ap;
    logic [ADDR_W-1:0] w_cand;
    logic              w_group;
    logic              w_try;
    logic              w_in_range;
    logic              w_issue;
    logic              w_hit;

    // frame qualification on the incoming transaction
    assign w_rx_is_ap = (i_receiver_addr == i_target_bssid);
    assign w_tx_is_ap = (i_transmitter_addr == i_target_bssid);
    assign w_cand     = w_rx_is_ap ? i_transmitter_addr : i_receiver_addr;
    assign w_group    = (w_cand[ADDR_W-1:24] == MCAST_V4_PREFIX)
                     || (w_cand[ADDR_W-1:24] == MCAST_V6_PREFIX);
    assign w_try      = (i_frame_length > MIN_FRAME_LEN)
                     && (i_receiver_addr != BCAST_ADDR)
                     && (w_rx_is_ap || w_tx_is_ap)
                     && !w_group
                     && (r_count < CW'(MAX_STATIONS));
    assign w_in_range = KW'(i_entry_index) < KW'(r_count);

    // table scan helpers
    assign w_issue = r_k < r_count;
    assign w_hit   = r_pend && (i_rdata.addr == r_cand);

    assign o_in_ready = (r_state == S_IDLE);

    // memory port control
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_wk;
        o_wdata = '{sel: r_sel_val, addr: i_rdata.addr};
        o_raddr = r_k[IW-1:0];
        unique case (r_state)
            S_INSERT: begin
                o_we    = 1'b1;
                o_waddr = r_count[IW-1:0];
                o_wdata = '{sel: 1'b0, addr: r_cand};
            end
            S_INDEX_RD: begin
                o_raddr = r_idx[IW-1:0];
            end
            S_INDEX_DATA: begin
                o_we    = r_toggle;
                o_waddr = r_idx[IW-1:0];
                o_wdata = '{sel: ~i_rdata.sel, addr: i_rdata.addr};
            end
            S_SWEEP: begin
                o_we = r_pend;
            end
            default: begin
            end
        endcase
    end

    // request sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // result taken with nothing new to load behind it
            if (o_out_valid && i_out_ready && (r_state != S_PUSH)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_k           <= '0;
                        r_pend        <= 1'b0;
                        r_cand        <= w_cand;
                        r_idx         <= KW'(i_entry_index);
                        r_toggle      <= (i_req_type == REQ_TOGGLE);
                        r_sel_val     <= (i_req_type == REQ_SEL_ALL);
                        r_res_learned <= 1'b0;
                        r_res_addr    <= '0;
                        r_res_sel     <= 1'b0;
                        r_res_valid   <= 1'b0;
                        unique case (t_req'(i_req_type))
                            REQ_FRAME: begin
                                r_state <= w_try ? S_SEARCH : S_PUSH;
                            end
                            REQ_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_PUSH;
                            end
                            REQ_READ, REQ_TOGGLE: begin
                                r_state <= w_in_range ? S_INDEX_RD : S_PUSH;
                            end
                            REQ_SEL_ALL, REQ_DESEL_ALL: begin
                                r_state <= S_SWEEP;
                            end
                            default: begin
                                r_state <= S_PUSH;
                            end
                        endcase
                    end
                end
                // look for the candidate among the learned entries
                S_SEARCH: begin
                    r_pend <= w_issue;
                    if (w_issue) begin
                        r_k <= r_k + 1'b1;
                    end
                    if (w_hit) begin
                        r_state <= S_PUSH;
                    end else if (!w_issue && !r_pend) begin
                        r_state <= S_INSERT;
                    end
                end
                S_INSERT: begin
                    r_count       <= r_count + 1'b1;
                    r_res_learned <= 1'b1;
                    r_res_addr    <= r_cand;
                    r_state       <= S_PUSH;
                end
                S_INDEX_RD: begin
                    r_state <= S_INDEX_DATA;
                end
                S_INDEX_DATA: begin
                    r_res_addr  <= i_rdata.addr;
                    r_res_sel   <= r_toggle ? ~i_rdata.sel : i_rdata.sel;
                    r_res_valid <= 1'b1;
                    r_state     <= S_PUSH;
                end
                // read each learned entry and write back its new selection
                S_SWEEP: begin
                    r_pend <= w_issue;
                    r_wk   <= r_k[IW-1:0];
                    if (w_issue) begin
                        r_k <= r_k + 1'b1;
                    end
                    if (!w_issue && !r_pend) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid      <= 1'b1;
                        o_station_count  <= CNT_OUT_W'(r_count);
                        o_learned_new    <= r_res_learned;
                        o_entry_addr     <= r_res_addr;
                        o_entry_selected <= r_res_sel;
                        o_entry_valid    <= r_res_valid;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/station_address_learner.sv
// channel   | direction | handshake                 | payload
// request   | in        | i_in_valid / o_in_ready   | req_type, addresses, length, index
// result    | out       | o_out_valid / i_out_ready | count, learned, entry fields
// config    | in        | psel penable pwrite       | target_bssid at byte address 0
//
// a frame that inserts reads the entries, one a cycle, drains the last read, writes
// the new entry; select all / deselect all read and write back each entry; read and
// toggle read the indexed entry; clear and skipped frames go straight to the result
// the next transaction is taken in the cycle after the result is loaded
// reset clears the count but not the table words: entries at or above the
// count are never read and new entries are written with selection cleared
// a finished result waits in the output register while the next request is taken;
// a new result is held back until the waiting one has been taken
`timescale 1ns / 1ps

`include "station_address_learner_assert.svh"

module station_address_learner import sal_pkg::*; #(
    parameter int MAX_STATIONS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [ADDR_W-1:0]    i_receiver_addr,
    input  logic [ADDR_W-1:0]    i_transmitter_addr,
    input  logic [LEN_W-1:0]     i_frame_length,
    input  logic [IDX_W-1:0]     i_entry_index,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CNT_OUT_W-1:0] o_station_count,
    output logic                 o_learned_new,
    output logic [ADDR_W-1:0]    o_entry_addr,
    output logic                 o_entry_selected,
    output logic                 o_entry_valid,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam int  IW         = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam logic REG_TARGET = 1'b0;

    logic [ADDR_W-1:0] r_target_bssid;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    t_entry            w_wdata;
    logic [IW-1:0]     w_raddr;
    t_entry            w_rdata;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_TARGET) ? {16'b0, r_target_bssid} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_bssid <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[3] == REG_TARGET)) begin
            r_target_bssid <= pwdata[ADDR_W-1:0];
        end
    end

    // request sequencer
    sal_engine #(
        .MAX_STATIONS (MAX_STATIONS),
        .IW           (IW)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_target_bssid     (r_target_bssid),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_receiver_addr    (i_receiver_addr),
        .i_transmitter_addr (i_transmitter_addr),
        .i_frame_length     (i_frame_length),
        .i_entry_index      (i_entry_index),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_station_count    (o_station_count),
        .o_learned_new      (o_learned_new),
        .o_entry_addr       (o_entry_addr),
        .o_entry_selected   (o_entry_selected),
        .o_entry_valid      (o_entry_valid),
        .o_we               (w_we),
        .o_waddr            (w_waddr),
        .o_wdata            (w_wdata),
        .o_raddr            (w_raddr),
        .i_rdata            (w_rdata)
    );

    // station table with selection bits
    sal_table_ram #(
        .DEPTH (MAX_STATIONS),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // checks
    `SAL_ASSERT_NOW(a_no_write_idle, i_clk, i_rst_n, w_we, !o_in_ready, "table written while idle")
    `SAL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second transaction taken while busy")
    `SAL_ASSERT_NOW(a_learned_no_entry, i_clk, i_rst_n, o_out_valid && o_learned_new, !o_entry_valid && !o_entry_selected, "learned result carries entry fields")
    `SAL_ASSERT_NOW(a_invalid_unselected, i_clk, i_rst_n, o_out_valid && !o_entry_valid, !o_entry_selected, "selection reported for invalid entry")

endmodule
